@@ hw/rtl/linear_probe_hash_table_core_assert.svh @@
// Assertion macros for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// Checked on every rising edge of clk_i outside of reset.
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define LPHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/lpht_pkg.sv @@
`default_nettype none

package lpht_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  localparam int unsigned KEY_IN_W  = 16;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CNT_W     = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned BASE_SIZE = 32;

  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_SIZE_LEVEL = 2'd0;

endpackage

`default_nettype wire

@@ hw/rtl/lpht_ram.sv @@
`default_nettype none

module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/lpht_cfg.sv @@
`default_nettype none

module lpht_cfg
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [APB_ADDR_W-1:0]              paddr,
  input  wire [APB_DATA_W-1:0]              pwdata,
  output logic [APB_DATA_W-1:0]             prdata,
  output logic                              pready,
  output logic [$clog2(TABLE_DEPTH)-1:0]    size_mask_o,
  output logic [$clog2(TABLE_DEPTH):0]      size_o,
  output logic [$clog2(TABLE_DEPTH):0]      limit_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = AW + 8;

  logic [LEVEL_W-1:0] level_q, level_d;
  logic               wr_en;
  logic [SW-1:0]      shifted;
  logic [SW-1:0]      sz_full;
  logic [SW-1:0]      sz_minus1;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_SIZE_LEVEL);

  always_comb begin
    level_d = level_q;
    if (wr_en) begin
      level_d = pwdata[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else begin
      level_q <= level_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_SIZE_LEVEL) begin
      prdata = APB_DATA_W'(level_q);
    end
  end

  // Levels past the memory depth saturate at the whole memory.
  assign shifted     = SW'(BASE_SIZE) << level_q;
  assign sz_full     = (shifted > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : shifted;
  assign sz_minus1   = sz_full - SW'(1);
  assign size_o      = sz_full[AW:0];
  assign size_mask_o = sz_minus1[AW-1:0];
  assign limit_o     = size_o - (size_o >> 2);

endmodule

`default_nettype wire

@@ hw/rtl/linear_probe_hash_table_core.sv @@
// Lookup and insert: the probed slots are read one after another through the table RAM's
// read port and one slot is checked per cycle; a new item is taken only after the previous
// one has finished. Clear and reset both run a clearing pass that writes every one of the
// TABLE_DEPTH RAM entries once; after the pass a clear returns its result through the done
// state. During the pass after reset in_ready_o is low.
// Reset also sets size_level to 0 and the entry count to 0.
`default_nettype none

`include "linear_probe_hash_table_core_assert.svh"

module linear_probe_hash_table_core
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_WIDTH   = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [APB_ADDR_W-1:0]  paddr,
  input  wire [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire [1:0]             kind_i,
  input  wire [KEY_IN_W-1:0]    key_i,
  input  wire [VALUE_W-1:0]     value_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic                  found_o,
  output logic [VALUE_W-1:0]    read_value_o,
  output logic                  over_limit_o,
  output logic                  full_res_o
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned MW    = 1 + KEY_WIDTH + VALUE_W;
  localparam int unsigned CMP_W = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [AW-1:0] size_mask;
  logic [AW:0]   size;
  logic [AW:0]   limit;

  lpht_cfg #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .size_mask_o(size_mask),
    .size_o     (size),
    .limit_o    (limit)
  );

  logic [1:0]           state_q, state_d;
  kind_e                kind_q, kind_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [VALUE_W-1:0]   value_q, value_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [AW-1:0]        eval_addr_q, eval_addr_d;
  logic                 pend_q, pend_d;
  logic [AW:0]          probes_q, probes_d;
  logic [AW-1:0]        sweep_q, sweep_d;
  logic                 sweep_res_q, sweep_res_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 res_found_q, res_found_d;
  logic [VALUE_W-1:0]   res_value_q, res_value_d;
  logic                 res_full_q, res_full_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q, out_found_d;
  logic [VALUE_W-1:0]   out_value_q, out_value_d;
  logic                 out_over_q, out_over_d;
  logic                 out_full_q, out_full_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [MW-1:0]        ram_wdata;
  logic [MW-1:0]        ram_rdata;
  logic                 rd_used;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [VALUE_W-1:0]   rd_value;
  logic [KEY_WIDTH-1:0] key_eff;
  logic [AW-1:0]        start_addr;
  logic                 accept;
  logic                 last_probe;

  lpht_ram #(
    .WIDTH(MW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  assign rd_used  = ram_rdata[MW-1];
  assign rd_key   = ram_rdata[MW-2 -: KEY_WIDTH];
  assign rd_value = ram_rdata[VALUE_W-1:0];

  assign key_eff = KEY_WIDTH'(key_i);
  // (key mod size + key) mod size reduces to twice the key modulo a power of two.
  assign start_addr = AW'({key_eff, 1'b0}) & size_mask;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_probe = ((probes_q + 1'b1) == size);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    value_d     = value_q;
    addr_d      = addr_q;
    eval_addr_d = eval_addr_q;
    pend_d      = pend_q;
    probes_d    = probes_q;
    sweep_d     = sweep_q;
    sweep_res_d = sweep_res_q;
    cnt_d       = cnt_q;
    res_found_d = res_found_q;
    res_value_d = res_value_q;
    res_full_d  = res_full_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_value_d = out_value_q;
    out_over_d  = out_over_q;
    out_full_d  = out_full_q;
    ram_we      = 1'b0;
    ram_waddr   = eval_addr_q;
    ram_wdata   = {1'b1, key_q, value_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == {AW{1'b1}}) begin
          state_d = sweep_res_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          kind_d      = kind_e'(kind_i);
          key_d       = key_eff;
          value_d     = value_i;
          addr_d      = start_addr;
          pend_d      = 1'b0;
          probes_d    = '0;
          res_found_d = 1'b0;
          res_value_d = '0;
          res_full_d  = 1'b0;
          case (kind_e'(kind_i))
            KIND_LOOKUP, KIND_INSERT: begin
              state_d = ST_PROBE;
            end
            KIND_CLEAR: begin
              sweep_d     = '0;
              sweep_res_d = 1'b1;
              cnt_d       = '0;
              state_d     = ST_SWEEP;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_PROBE: begin
        // Reads run one slot ahead; the slot read last cycle is checked here.
        addr_d      = (addr_q + 1'b1) & size_mask;
        eval_addr_d = addr_q;
        pend_d      = 1'b1;
        if (pend_q) begin
          if (!rd_used) begin
            if (kind_q == KIND_INSERT) begin
              ram_we = 1'b1;
              if (cnt_q != CNT_MAX) begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            state_d = ST_DONE;
          end else if (kind_q == KIND_LOOKUP && rd_key == key_q) begin
            res_found_d = 1'b1;
            res_value_d = rd_value;
            state_d     = ST_DONE;
          end else if (last_probe) begin
            res_full_d = (kind_q == KIND_INSERT);
            state_d    = ST_DONE;
          end else begin
            probes_d = probes_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_value_d = res_value_q;
          out_full_d  = res_full_q;
          out_over_d  = (kind_q == KIND_INSERT) && (CMP_W'(cnt_q) > CMP_W'(limit));
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      sweep_res_q <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      sweep_res_q <= sweep_res_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    value_q     <= value_d;
    addr_q      <= addr_d;
    eval_addr_q <= eval_addr_d;
    probes_q    <= probes_d;
    res_found_q <= res_found_d;
    res_value_q <= res_value_d;
    res_full_q  <= res_full_d;
    out_found_q <= out_found_d;
    out_value_q <= out_value_d;
    out_over_q  <= out_over_d;
    out_full_q  <= out_full_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign read_value_o = out_value_q;
  assign over_limit_o = out_over_q;
  assign full_res_o   = out_full_q;

  `LPHT_ASSERT(a_probe_write_empty, (ram_we && state_q == ST_PROBE) |-> (pend_q && !rd_used && kind_q == KIND_INSERT), "table write during probe without an empty slot")
  `LPHT_ASSERT(a_count_step, 1'b1 |=> (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1 || cnt_q == '0), "entry count moved by more than one")
  `LPHT_ASSERT(a_probe_bound, (state_q == ST_PROBE) |-> (probes_q < size), "probe count reached the table size")
  `LPHT_ASSERT(a_one_item, (in_valid_i && in_ready_o) |=> !in_ready_o, "second input transfer before the first item finished")
  `LPHT_ASSERT_ALWAYS(a_idle_no_write, (state_q == ST_IDLE) |-> !ram_we, "table written while idle")

endmodule

`default_nettype wire
